// File: hdl/sacl_pkg.sv
`timescale 1ns / 1ps
package sacl_pkg;

  localparam int FracBits = 16;
  localparam int NumNodes = 7;
  localparam int DivStages = 10;
  // floor(x / 6) == (x * RecipSix) >> 34 for every x below 2^31.
  localparam logic [31:0] RecipSix = 32'd2863311531;
  localparam logic [6:0] WeightDivOdd = 7'd105;
  localparam logic signed [63:0] QMax = 64'sd2147483647;
  localparam logic signed [63:0] QMin = -64'sd2147483648;

  typedef logic [2:0] node_idx_t;
  localparam node_idx_t LastIdx = node_idx_t'(NumNodes - 1);

  typedef struct packed {
    logic signed [31:0] lin_x;
    logic signed [31:0] lin_y;
    logic signed [31:0] quad_x;
    logic signed [31:0] quad_y;
    logic signed [31:0] cubic_x;
    logic signed [31:0] cubic_y;
    logic [30:0]        span;
  } coef_t;

  typedef struct packed {
    logic       valid;
    logic       last;
    node_idx_t  idx;
    logic [30:0] u;
    coef_t      coef;
  } node_t;

  typedef struct packed {
    logic        valid;
    logic        last;
    node_idx_t   idx;
    logic        ovf;
    logic [30:0] span;
  } tag_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > QMax) begin
      return 32'sh7fffffff;
    end else if (v < QMin) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > QMax) || (v < QMin);
  endfunction

  function automatic logic [8:0] node_weight(input node_idx_t idx);
    logic [8:0] w;
    unique case (idx)
      3'd0, 3'd6: w = 9'd41;
      3'd1, 3'd5: w = 9'd216;
      3'd2, 3'd4: w = 9'd27;
      3'd3:       w = 9'd272;
      default:    w = 9'd0;
    endcase
    return w;
  endfunction

endpackage

// File: hdl/sacl_issue.sv
`timescale 1ns / 1ps
module sacl_issue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  sacl_pkg::coef_t    coef_i,
  output logic               busy_o,
  output sacl_pkg::node_t    node_o
);
  import sacl_pkg::*;

  node_t       node_q, node_d;
  logic [28:0] qh_q, qh_d;
  logic [2:0]  rh_q, rh_d;
  logic [2:0]  r_q, r_d;
  logic [62:0] recip_prod;
  logic [28:0] qh_in;
  logic [2:0]  rh_in;
  logic [3:0]  rsum;
  logic        wrap;
  logic        accept;

  assign busy_o = node_q.valid && (node_q.idx != LastIdx);
  assign accept = start_i && !busy_o;
  assign node_o = node_q;

  // Split the span into span/6 and its remainder, so each node position
  // follows from the previous one by an add and a small carry.
  assign recip_prod = 63'(coef_i.span) * 63'(RecipSix);
  assign qh_in = recip_prod[62:34];
  assign rh_in = 3'(coef_i.span - 31'(31'(qh_in) * 31'd6));
  assign rsum = 4'(r_q) + 4'(rh_q);
  assign wrap = rsum >= 4'd6;

  always_comb begin
    node_d = node_q;
    qh_d = qh_q;
    rh_d = rh_q;
    r_d = r_q;
    if (accept) begin
      node_d.valid = 1'b1;
      node_d.last = 1'b0;
      node_d.idx = '0;
      node_d.u = '0;
      node_d.coef = coef_i;
      qh_d = qh_in;
      rh_d = rh_in;
      r_d = '0;
    end else if (busy_o) begin
      node_d.idx = node_q.idx + 3'd1;
      node_d.last = (node_q.idx + 3'd1) == LastIdx;
      node_d.u = node_q.u + 31'(qh_q) + 31'(wrap);
      r_d = wrap ? 3'(rsum - 4'd6) : 3'(rsum);
    end else begin
      node_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q <= '0;
      qh_q <= '0;
      rh_q <= '0;
      r_q <= '0;
    end else begin
      node_q <= node_d;
      qh_q <= qh_d;
      rh_q <= rh_d;
      r_q <= r_d;
    end
  end

endmodule

// File: hdl/sacl_tangent.sv
`timescale 1ns / 1ps
module sacl_tangent (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sacl_pkg::node_t  node_i,
  output sacl_pkg::tag_t   tag_o,
  output logic [63:0]      sq_sum_o
);
  import sacl_pkg::*;

  tag_t tag1_q, tag2_q, tag3_q, tag4_q, tag5_q, tag6_q;
  tag_t tag1_d, tag2_d, tag3_d, tag4_d, tag5_d, tag6_d;

  // Stage 1: products with u.
  logic [61:0]        uu1_q;
  logic signed [63:0] cux1_q, cuy1_q;
  logic signed [31:0] bx1_q, by1_q, dx1_q, dy1_q;
  // Stage 2: u squared and the quadratic terms.
  logic [30:0]        u2_2_q, u2_d;
  logic signed [31:0] px2_q, py2_q, px_d, py_d;
  logic signed [31:0] bx2_q, by2_q, dx2_q, dy2_q;
  logic signed [31:0] csx, csy;
  logic [45:0]        uu_sh;
  // Stage 3: cubic products.
  logic signed [63:0] dux3_q, duy3_q;
  logic signed [31:0] px3_q, py3_q, bx3_q, by3_q;
  // Stage 4: tangent per axis.
  logic signed [31:0] tx4_q, ty4_q, tx_d, ty_d;
  logic signed [31:0] qsx, qsy;
  logic signed [63:0] qx64, qy64, sumx, sumy;
  // Stage 5 and 6: squares and their sum.
  logic [63:0]        sqx5_q, sqy5_q, sum6_q;
  logic [31:0]        magx, magy;
  logic               ovf2, ovf4;

  assign csx = sat32(cux1_q >>> FracBits);
  assign csy = sat32(cuy1_q >>> FracBits);
  assign uu_sh = uu1_q[61:16];
  assign u2_d = (uu_sh > 46'(QMax)) ? 31'h7fffffff : uu_sh[30:0];
  assign px_d = sat32({{31{csx[31]}}, csx, 1'b0});
  assign py_d = sat32({{31{csy[31]}}, csy, 1'b0});
  assign ovf2 = (uu_sh > 46'(QMax)) || ovf32(cux1_q >>> FracBits)
      || ovf32(cuy1_q >>> FracBits)
      || ovf32({{31{csx[31]}}, csx, 1'b0}) || ovf32({{31{csy[31]}}, csy, 1'b0});

  assign qsx = sat32(dux3_q >>> FracBits);
  assign qsy = sat32(duy3_q >>> FracBits);
  assign qx64 = 64'(qsx) + (64'(qsx) <<< 1);
  assign qy64 = 64'(qsy) + (64'(qsy) <<< 1);
  assign sumx = 64'(bx3_q) + 64'(px3_q) + 64'(sat32(qx64));
  assign sumy = 64'(by3_q) + 64'(py3_q) + 64'(sat32(qy64));
  assign tx_d = sat32(sumx);
  assign ty_d = sat32(sumy);
  assign ovf4 = ovf32(dux3_q >>> FracBits) || ovf32(duy3_q >>> FracBits)
      || ovf32(qx64) || ovf32(qy64) || ovf32(sumx) || ovf32(sumy);

  assign magx = tx4_q[31] ? (~tx4_q + 32'd1) : tx4_q;
  assign magy = ty4_q[31] ? (~ty4_q + 32'd1) : ty4_q;

  always_comb begin
    tag1_d = '{valid: node_i.valid, last: node_i.last, idx: node_i.idx, ovf: 1'b0,
               span: node_i.coef.span};
    tag2_d = tag1_q;
    tag2_d.ovf = tag1_q.ovf || ovf2;
    tag3_d = tag2_q;
    tag4_d = tag3_q;
    tag4_d.ovf = tag3_q.ovf || ovf4;
    tag5_d = tag4_q;
    tag6_d = tag5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
      tag4_q <= '0;
      tag5_q <= '0;
      tag6_q <= '0;
    end else begin
      tag1_q <= tag1_d;
      tag2_q <= tag2_d;
      tag3_q <= tag3_d;
      tag4_q <= tag4_d;
      tag5_q <= tag5_d;
      tag6_q <= tag6_d;
    end
  end

  always_ff @(posedge clk_i) begin
    uu1_q <= 62'(node_i.u) * 62'(node_i.u);
    cux1_q <= node_i.coef.quad_x * $signed({1'b0, node_i.u});
    cuy1_q <= node_i.coef.quad_y * $signed({1'b0, node_i.u});
    bx1_q <= node_i.coef.lin_x;
    by1_q <= node_i.coef.lin_y;
    dx1_q <= node_i.coef.cubic_x;
    dy1_q <= node_i.coef.cubic_y;

    u2_2_q <= u2_d;
    px2_q <= px_d;
    py2_q <= py_d;
    bx2_q <= bx1_q;
    by2_q <= by1_q;
    dx2_q <= dx1_q;
    dy2_q <= dy1_q;

    dux3_q <= dx2_q * $signed({1'b0, u2_2_q});
    duy3_q <= dy2_q * $signed({1'b0, u2_2_q});
    px3_q <= px2_q;
    py3_q <= py2_q;
    bx3_q <= bx2_q;
    by3_q <= by2_q;

    tx4_q <= tx_d;
    ty4_q <= ty_d;

    sqx5_q <= 64'(magx) * 64'(magx);
    sqy5_q <= 64'(magy) * 64'(magy);

    sum6_q <= sqx5_q + sqy5_q;
  end

  assign tag_o = tag6_q;
  assign sq_sum_o = sum6_q;

endmodule

// File: hdl/sacl_isqrt.sv
`timescale 1ns / 1ps
module sacl_isqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sacl_pkg::tag_t  tag_i,
  input  logic [63:0]     radicand_i,
  output sacl_pkg::tag_t  tag_o,
  output logic [31:0]     root_o
);
  import sacl_pkg::*;

  // One result bit per stage, most significant first.
  tag_t        tag_q [33];
  logic [63:0] rem_q [33];
  logic [63:0] res_q [33];

  assign tag_q[0] = tag_i;
  assign rem_q[0] = radicand_i;
  assign res_q[0] = '0;

  for (genvar i = 0; i < 32; i++) begin : g_stage
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * i);
    logic [63:0] trial;
    logic        take;
    assign trial = res_q[i] + Bit;
    assign take = rem_q[i] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[i+1] <= '0;
      end else begin
        tag_q[i+1] <= tag_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i+1] <= take ? (rem_q[i] - trial) : rem_q[i];
      res_q[i+1] <= take ? ((res_q[i] >> 1) + Bit) : (res_q[i] >> 1);
    end
  end

  assign tag_o = tag_q[32];
  assign root_o = res_q[32][31:0];

endmodule

// File: hdl/sacl_final.sv
`timescale 1ns / 1ps
module sacl_final (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sacl_pkg::tag_t  tag_i,
  input  logic [31:0]     root_i,
  output logic            done_o,
  output logic [30:0]     arc_length_o,
  output logic            overflowed_o
);
  import sacl_pkg::*;

  function automatic logic [10:0] div_step(input logic [6:0] rem, input logic [3:0] bits);
    logic [7:0] r;
    logic [3:0] q;
    r = {1'b0, rem};
    q = '0;
    for (int b = 3; b >= 0; b--) begin
      r = {r[6:0], bits[b]};
      if (r >= 8'(WeightDivOdd)) begin
        r = r - 8'(WeightDivOdd);
        q[b] = 1'b1;
      end
    end
    return {r[6:0], q};
  endfunction

  tag_t        wtag_q;
  logic [40:0] wprod_q;
  logic        acc_valid_q;
  logic [42:0] acc_q, acc_d;
  logic        acc_ovf_q, acc_ovf_d;
  logic [30:0] acc_span_q;

  // Dividing by 840 is a shift by 3 then a long division by 105.
  logic        dv_valid_q [DivStages+1];
  logic        dv_ovf_q   [DivStages+1];
  logic [30:0] dv_span_q  [DivStages+1];
  logic [39:0] dv_x_q     [DivStages+1];
  logic [39:0] dv_quot_q  [DivStages+1];
  logic [6:0]  dv_rem_q   [DivStages+1];

  logic        m_valid_q, m_ovf_q;
  logic [62:0] m_prod_q;
  logic        o_valid_q, o_ovf_q;
  logic [30:0] o_len_q;
  logic [46:0] scaled;
  logic        too_big;

  assign acc_d = (wtag_q.idx == '0) ? 43'(wprod_q) : acc_q + 43'(wprod_q);
  assign acc_ovf_d = (wtag_q.idx == '0) ? wtag_q.ovf : (acc_ovf_q || wtag_q.ovf);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wtag_q <= '0;
      acc_valid_q <= 1'b0;
    end else begin
      wtag_q <= tag_i;
      acc_valid_q <= wtag_q.valid && wtag_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    wprod_q <= 41'(root_i) * 41'(node_weight(tag_i.idx));
    if (wtag_q.valid) begin
      acc_q <= acc_d;
      acc_ovf_q <= acc_ovf_d;
      acc_span_q <= wtag_q.span;
    end
  end

  assign dv_valid_q[0] = acc_valid_q;
  assign dv_ovf_q[0] = acc_ovf_q;
  assign dv_span_q[0] = acc_span_q;
  assign dv_x_q[0] = acc_q[42:3];
  assign dv_quot_q[0] = '0;
  assign dv_rem_q[0] = '0;

  for (genvar j = 0; j < DivStages; j++) begin : g_div
    logic [10:0] step;
    assign step = div_step(dv_rem_q[j], dv_x_q[j][39 - 4 * j -: 4]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_valid_q[j+1] <= 1'b0;
      end else begin
        dv_valid_q[j+1] <= dv_valid_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_ovf_q[j+1] <= dv_ovf_q[j];
      dv_span_q[j+1] <= dv_span_q[j];
      dv_x_q[j+1] <= dv_x_q[j];
      dv_quot_q[j+1] <= {dv_quot_q[j][35:0], step[3:0]};
      dv_rem_q[j+1] <= step[10:4];
    end
  end

  assign scaled = m_prod_q[62:16];
  assign too_big = scaled > 47'(QMax);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      m_valid_q <= dv_valid_q[DivStages];
      o_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_prod_q <= 63'(dv_quot_q[DivStages][31:0]) * 63'(dv_span_q[DivStages]);
    m_ovf_q <= dv_ovf_q[DivStages];
    o_len_q <= too_big ? 31'h7fffffff : scaled[30:0];
    o_ovf_q <= m_ovf_q || too_big;
  end

  assign done_o = o_valid_q;
  assign arc_length_o = o_len_q;
  assign overflowed_o = o_ovf_q;

endmodule

// File: hdl/spline_arc_length_newton_cotes_top.sv
`timescale 1ns / 1ps
// A new request is taken only while the node sequencer is free (busy_o low): it feeds one of the seven
// quadrature nodes per cycle into a shared tangent, square-root and weighting pipeline.
// A result strobe (done_o) follows each accepted request; a new
// request may be accepted while earlier ones are still in the pipeline.
// done_o is high for one cycle only and cannot be held off by the receiver.
// rst_ni clears all valid bits and the sequencer asynchronously; payload is not reset.
module spline_arc_length_newton_cotes_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] lin_x_i,
  input  logic signed [31:0] lin_y_i,
  input  logic signed [31:0] quad_x_i,
  input  logic signed [31:0] quad_y_i,
  input  logic signed [31:0] cubic_x_i,
  input  logic signed [31:0] cubic_y_i,
  input  logic [30:0]        span_i,
  output logic               done_o,
  output logic [30:0]        arc_length_o,
  output logic               overflowed_o
);
  import sacl_pkg::*;

  coef_t       coef;
  node_t       node;
  tag_t        tan_tag, root_tag;
  logic [63:0] sq_sum;
  logic [31:0] root;

  assign coef = '{lin_x: lin_x_i, lin_y: lin_y_i, quad_x: quad_x_i, quad_y: quad_y_i,
                  cubic_x: cubic_x_i, cubic_y: cubic_y_i, span: span_i};

  sacl_issue u_issue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .coef_i  (coef),
    .busy_o  (busy_o),
    .node_o  (node)
  );

  sacl_tangent u_tangent (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .node_i   (node),
    .tag_o    (tan_tag),
    .sq_sum_o (sq_sum)
  );

  sacl_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tag_i      (tan_tag),
    .radicand_i (sq_sum),
    .tag_o      (root_tag),
    .root_o     (root)
  );

  sacl_final u_final (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tag_i        (root_tag),
    .root_i       (root),
    .done_o       (done_o),
    .arc_length_o (arc_length_o),
    .overflowed_o (overflowed_o)
  );

endmodule

// File: hdl/sacl_checker.sv
`timescale 1ns / 1ps
module sacl_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);

  // An accepted request keeps the node sequencer busy until it issues its last node.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (start_i && !busy_o) |=> busy_o)
    else $error("busy_o low right after an accepted request");

  a_free_after_seven: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (start_i && !busy_o) |-> ##7 !busy_o)
    else $error("sequencer still busy seven cycles after a request");

  // Requests are spaced apart by the busy node sequencer, so results are too.
  a_done_spacing1: assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_o |=> !done_o)
    else $error("two results in adjacent cycles");

  a_done_spacing2: assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_o |-> ##2 !done_o)
    else $error("two results two cycles apart");

endmodule

bind spline_arc_length_newton_cotes_top sacl_checker u_sacl_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o)
);
